>>> sv/tra_pkg.sv
package tra_pkg;

    // Field widths
    localparam int TIME_W    = 64;
    localparam int PIX_W     = 8;
    localparam int RGB_W     = 3 * PIX_W;
    localparam int CFG_DIM_W = 13;
    localparam int WIN_W     = 32;
    localparam int AREA_W    = 2 * CFG_DIM_W;
    localparam int S_TDATA_W = TIME_W + RGB_W;
    localparam int M_TDATA_W = RGB_W;

    // Frame store geometry
    localparam int FRAME_PIXELS = 1048576;
    localparam int ADDR_W       = $clog2(FRAME_PIXELS);
    localparam int POS_W        = ADDR_W + 1;

    // Blend weight, unsigned Q1.16
    localparam int FRAC_W   = 16;
    localparam int WEIGHT_W = FRAC_W + 1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_W;
    localparam int PROD_W   = WEIGHT_W + PIX_W;
    localparam int DIV_CNT_W = $clog2(FRAC_W);

    localparam logic [TIME_W-1:0] MIN_GAP_US = 64'd1000000;

    // Register reset values
    localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 13'd480;
    localparam logic [WIN_W-1:0]     WINDOW_RST = 32'd10000000;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_WINDOW   = 2'd2;

    typedef struct packed {
        logic             start;
        logic [WIN_W-1:0] dividend;
        logic [WIN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

>>> sv/tra_div.sv
module tra_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  tra_pkg::div_req_t         req,
    output tra_pkg::div_status_t      status,
    output logic [tra_pkg::FRAC_W-1:0] quotient
);

    localparam logic [tra_pkg::DIV_CNT_W-1:0] CNT_LAST =
        tra_pkg::DIV_CNT_W'(tra_pkg::FRAC_W - 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [tra_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [tra_pkg::WIN_W-1:0]     rem_reg, rem_next;
    logic [tra_pkg::WIN_W-1:0]     div_reg, div_next;
    logic [tra_pkg::FRAC_W-1:0]    quo_reg, quo_next;

    logic [tra_pkg::WIN_W:0] rem_sh;
    logic [tra_pkg::WIN_W:0] diff;
    logic                    fits;

    // One quotient bit per cycle; the remainder always stays below the divisor
    always_comb begin
        rem_sh = {rem_reg, 1'b0};
        diff   = rem_sh - {1'b0, div_reg};
        fits   = rem_sh >= {1'b0, div_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;

        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = req.dividend;
            div_next  = req.divisor;
            quo_next  = '0;
        end else if (busy_reg) begin
            rem_next = fits ? diff[tra_pkg::WIN_W-1:0] : rem_sh[tra_pkg::WIN_W-1:0];
            quo_next = {quo_reg[tra_pkg::FRAC_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

>>> sv/tra_lane.sv
module tra_lane (
    input  logic                          aclk,
    input  logic [tra_pkg::WEIGHT_W-1:0]  alpha,
    input  logic [tra_pkg::PIX_W-1:0]     new_px,
    input  logic [tra_pkg::PIX_W-1:0]     old_px,
    output logic [tra_pkg::PIX_W-1:0]     mix
);

    localparam int Q_W = tra_pkg::PROD_W - tra_pkg::FRAC_W;
    localparam logic [tra_pkg::FRAC_W-1:0] HALF = tra_pkg::FRAC_W'(1) << (tra_pkg::FRAC_W - 1);
    localparam logic [Q_W-1:0] PIX_MAX = Q_W'((1 << tra_pkg::PIX_W) - 1);

    logic [tra_pkg::WEIGHT_W-1:0] comp_alpha;
    logic [tra_pkg::PROD_W-1:0]   prod_new_reg, prod_new_next;
    logic [tra_pkg::PROD_W-1:0]   prod_old_reg, prod_old_next;
    logic [tra_pkg::PROD_W-1:0]   sum;
    logic [Q_W-1:0]               quo;
    logic [tra_pkg::FRAC_W-1:0]   rem;
    logic                         round_up;
    logic [Q_W-1:0]               quo_rnd;
    logic [tra_pkg::PIX_W-1:0]    mix_reg, mix_next;

    // Stage 1: weight both pixels
    always_comb begin
        comp_alpha    = tra_pkg::WEIGHT_ONE - alpha;
        prod_new_next = tra_pkg::PROD_W'(alpha) * tra_pkg::PROD_W'(new_px);
        prod_old_next = tra_pkg::PROD_W'(comp_alpha) * tra_pkg::PROD_W'(old_px);
    end

    // Stage 2: add, round half to even, clamp
    always_comb begin
        sum      = prod_new_reg + prod_old_reg;
        quo      = sum[tra_pkg::PROD_W-1:tra_pkg::FRAC_W];
        rem      = sum[tra_pkg::FRAC_W-1:0];
        round_up = (rem > HALF) || ((rem == HALF) && quo[0]);
        quo_rnd  = quo + Q_W'(round_up);
        mix_next = (quo_rnd > PIX_MAX) ? PIX_MAX[tra_pkg::PIX_W-1:0]
                                       : quo_rnd[tra_pkg::PIX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        prod_new_reg <= prod_new_next;
        prod_old_reg <= prod_old_next;
        mix_reg      <= mix_next;
    end

    assign mix = mix_reg;

endmodule

>>> sv/tra_store.sv
module tra_store (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [tra_pkg::ADDR_W-1:0]  wr_addr,
    input  logic [tra_pkg::RGB_W-1:0]   wr_data,
    input  logic [tra_pkg::ADDR_W-1:0]  rd_addr,
    output logic [tra_pkg::RGB_W-1:0]   rd_data
);

    logic [tra_pkg::RGB_W-1:0] mem [0:tra_pkg::FRAME_PIXELS-1];
    logic [tra_pkg::RGB_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/timed_running_average_frame_core.sv
// Channel  Dir  Beat                                  Handshake
// s_       in   one RGB pixel, first pixel flag        s_tvalid / s_tready
// m_       out  averaged RGB pixel, updated flag       m_tvalid / m_tready
// cfg_     in   register index and write data          cfg_valid / cfg_ready
//
// After acceptance a pixel steps through S_DECIDE, S_READ, S_MUL, S_RND and S_DONE
// before the next pixel can be taken, set by the store read latency and the two-stage blend lanes.
// A frame blended below full weight first waits in S_DIV for the 16-step weight divider.
// The result register frees the engine, which stalls only when a new result meets a full one.
// Reset clears control state only; the frame store holds garbage until written,
// so there is no clearing pass.
module timed_running_average_frame_core (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tra_pkg::S_TDATA_W-1:0]   s_tdata,   // frame_time, red, green, blue
    input  logic [0:0]                      s_tuser,   // first_pixel

    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tra_pkg::M_TDATA_W-1:0]   m_tdata,   // avg_red, avg_green, avg_blue
    output logic [0:0]                      m_tuser,   // frame_updated

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tra_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tra_pkg::WIN_W-1:0]       cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV,
        S_READ,
        S_MUL,
        S_RND,
        S_DONE
    } state_t;

    localparam int PW = tra_pkg::PIX_W;

    state_t                          state_reg, state_next;
    logic [tra_pkg::CFG_DIM_W-1:0]   width_reg, width_next;
    logic [tra_pkg::CFG_DIM_W-1:0]   height_reg, height_next;
    logic [tra_pkg::WIN_W-1:0]       window_reg, window_next;
    logic                            have_avg_reg, have_avg_next;
    logic [tra_pkg::TIME_W-1:0]      last_time_reg, last_time_next;
    logic                            taken_reg, taken_next;
    logic                            initial_reg, initial_next;
    logic [tra_pkg::WEIGHT_W-1:0]    weight_reg, weight_next;
    logic [tra_pkg::POS_W-1:0]       pixel_index_reg, pixel_index_next;
    logic                            m_tvalid_reg, m_tvalid_next;

    logic [tra_pkg::POS_W-1:0]       limit_reg, limit_next;
    logic [tra_pkg::TIME_W-1:0]      ts_reg, ts_next;
    logic                            first_reg, first_next;
    logic [tra_pkg::RGB_W-1:0]       pix_reg, pix_next;
    logic [tra_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic                            in_range_reg, in_range_next;
    logic [tra_pkg::RGB_W-1:0]       old_reg, old_next;
    logic [tra_pkg::RGB_W-1:0]       m_data_reg, m_data_next;
    logic                            m_upd_reg, m_upd_next;

    logic [tra_pkg::AREA_W-1:0]      area;
    logic [tra_pkg::TIME_W-1:0]      gap;
    logic                            skip;
    logic                            full_weight;
    logic                            out_free;

    tra_pkg::div_req_t               div_req;
    tra_pkg::div_status_t            div_status;
    logic [tra_pkg::FRAC_W-1:0]      div_quo;

    logic                            wr_en;
    logic [tra_pkg::ADDR_W-1:0]      rd_addr;
    logic [tra_pkg::RGB_W-1:0]       rd_data;
    logic [tra_pkg::RGB_W-1:0]       old_px;
    logic [tra_pkg::RGB_W-1:0]       mix;

    tra_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .status   (div_status),
        .quotient (div_quo)
    );

    // After the read, hold the address on the current position so the old pixel
    // stays put while the result waits
    assign rd_addr = (state_reg == S_READ) ? pixel_index_reg[tra_pkg::ADDR_W-1:0]
                                           : pos_reg[tra_pkg::ADDR_W-1:0];

    tra_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (pos_reg[tra_pkg::ADDR_W-1:0]),
        .wr_data (mix),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // A copied frame weights the old pixel by zero; keep unwritten entries out of it
    assign old_px = initial_reg ? '0 : rd_data;

    tra_lane u_lane_red (
        .aclk   (aclk),
        .alpha  (weight_reg),
        .new_px (pix_reg[PW-1:0]),
        .old_px (old_px[PW-1:0]),
        .mix    (mix[PW-1:0])
    );

    tra_lane u_lane_green (
        .aclk   (aclk),
        .alpha  (weight_reg),
        .new_px (pix_reg[2*PW-1:PW]),
        .old_px (old_px[2*PW-1:PW]),
        .mix    (mix[2*PW-1:PW])
    );

    tra_lane u_lane_blue (
        .aclk   (aclk),
        .alpha  (weight_reg),
        .new_px (pix_reg[3*PW-1:2*PW]),
        .old_px (old_px[3*PW-1:2*PW]),
        .mix    (mix[3*PW-1:2*PW])
    );

    always_comb begin
        area       = tra_pkg::AREA_W'(width_reg) * tra_pkg::AREA_W'(height_reg);
        limit_next = (area < tra_pkg::AREA_W'(tra_pkg::FRAME_PIXELS))
                   ? area[tra_pkg::POS_W-1:0]
                   : tra_pkg::POS_W'(tra_pkg::FRAME_PIXELS);

        gap         = ts_reg - last_time_reg;
        skip        = have_avg_reg && (gap < tra_pkg::MIN_GAP_US);
        full_weight = !have_avg_reg || (window_reg == '0)
                   || (gap >= tra_pkg::TIME_W'(window_reg));
        out_free    = !m_tvalid_reg || m_tready;

        div_req.start    = (state_reg == S_DECIDE) && first_reg && !skip && !full_weight;
        div_req.dividend = gap[tra_pkg::WIN_W-1:0];
        div_req.divisor  = window_reg;
    end

    always_comb begin
        state_next       = state_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        window_next      = window_reg;
        have_avg_next    = have_avg_reg;
        last_time_next   = last_time_reg;
        taken_next       = taken_reg;
        initial_next     = initial_reg;
        weight_next      = weight_reg;
        pixel_index_next = pixel_index_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;

        ts_next       = ts_reg;
        first_next    = first_reg;
        pix_next      = pix_reg;
        pos_next      = pos_reg;
        in_range_next = in_range_reg;
        old_next      = old_reg;
        m_data_next   = m_data_reg;
        m_upd_next    = m_upd_reg;
        wr_en         = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ts_next    = s_tdata[tra_pkg::TIME_W-1:0];
                    pix_next   = s_tdata[tra_pkg::S_TDATA_W-1:tra_pkg::TIME_W];
                    first_next = s_tuser[0];
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                state_next = S_READ;
                if (first_reg) begin
                    pixel_index_next = '0;
                    if (skip) begin
                        taken_next = 1'b0;
                    end else begin
                        taken_next     = 1'b1;
                        initial_next   = !have_avg_reg;
                        last_time_next = ts_reg;
                        have_avg_next  = (ts_reg != '0);
                        if (full_weight) begin
                            weight_next = tra_pkg::WEIGHT_ONE;
                        end else begin
                            state_next = S_DIV;
                        end
                    end
                end
            end
            S_DIV: begin
                if (div_status.done) begin
                    weight_next = tra_pkg::WEIGHT_W'(div_quo);
                    state_next  = S_READ;
                end
            end
            S_READ: begin
                pos_next      = pixel_index_reg;
                in_range_next = pixel_index_reg < limit_reg;
                // hold the position at the bound
                if (pixel_index_reg < limit_reg) begin
                    pixel_index_next = pixel_index_reg + 1'b1;
                end
                state_next = S_MUL;
            end
            S_MUL: begin
                old_next   = rd_data;
                state_next = S_RND;
            end
            S_RND: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (!in_range_reg) begin
                        m_data_next = '0;
                        m_upd_next  = 1'b0;
                    end else if (taken_reg) begin
                        m_data_next = mix;
                        m_upd_next  = 1'b1;
                        wr_en       = 1'b1;
                    end else begin
                        m_data_next = have_avg_reg ? old_reg : '0;
                        m_upd_next  = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // a size write drops the average and ends the current frame
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tra_pkg::CFG_FRAME_WIDTH: begin
                    width_next    = cfg_data[tra_pkg::CFG_DIM_W-1:0];
                    have_avg_next = 1'b0;
                    taken_next    = 1'b0;
                end
                tra_pkg::CFG_FRAME_HEIGHT: begin
                    height_next   = cfg_data[tra_pkg::CFG_DIM_W-1:0];
                    have_avg_next = 1'b0;
                    taken_next    = 1'b0;
                end
                tra_pkg::CFG_AVG_WINDOW: begin
                    window_next = cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            width_reg       <= tra_pkg::WIDTH_RST;
            height_reg      <= tra_pkg::HEIGHT_RST;
            window_reg      <= tra_pkg::WINDOW_RST;
            have_avg_reg    <= 1'b0;
            last_time_reg   <= '0;
            taken_reg       <= 1'b0;
            initial_reg     <= 1'b0;
            weight_reg      <= '0;
            pixel_index_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            window_reg      <= window_next;
            have_avg_reg    <= have_avg_next;
            last_time_reg   <= last_time_next;
            taken_reg       <= taken_next;
            initial_reg     <= initial_next;
            weight_reg      <= weight_next;
            pixel_index_reg <= pixel_index_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        limit_reg    <= limit_next;
        ts_reg       <= ts_next;
        first_reg    <= first_next;
        pix_reg      <= pix_next;
        pos_reg      <= pos_next;
        in_range_reg <= in_range_next;
        old_reg      <= old_next;
        m_data_reg   <= m_data_next;
        m_upd_reg    <= m_upd_next;
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_upd_reg;
    // take register writes only between pixels
    assign cfg_ready  = (state_reg == S_IDLE);

    a_store_write_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (taken_reg && in_range_reg))
        else $error("store written outside a taken frame");

    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (div_status.busy || div_status.done))
        else $error("waiting on an idle divider");

    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        weight_reg[tra_pkg::FRAC_W] |-> (weight_reg[tra_pkg::FRAC_W-1:0] == '0))
        else $error("blend weight above one");

endmodule

>>> dv/running_average_checker.sv
module running_average_checker (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [tra_pkg::S_TDATA_W-1:0]   s_tdata,   // frame_time, red, green, blue
    input  logic [0:0]                      s_tuser,   // first_pixel

    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [tra_pkg::M_TDATA_W-1:0]   m_tdata,   // avg_red, avg_green, avg_blue
    input  logic [0:0]                      m_tuser,   // frame_updated

    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [tra_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tra_pkg::WIN_W-1:0]       cfg_data,

    output int unsigned                     fail_count,
    output int unsigned                     pending_pixels
);

    typedef struct packed {
        logic [tra_pkg::PIX_W-1:0] red;
        logic [tra_pkg::PIX_W-1:0] green;
        logic [tra_pkg::PIX_W-1:0] blue;
        logic                      updated;
    } avg_pixel_t;

    // Running average as the block should hold it, packed red, green, blue from the top
    logic [tra_pkg::RGB_W-1:0]     avg_mem [int unsigned];
    logic                          avg_valid;
    logic                          in_taken;
    logic                          copy_frame;
    logic [tra_pkg::TIME_W-1:0]    last_take_us;
    logic [tra_pkg::WEIGHT_W-1:0]  weight_q16;
    logic [tra_pkg::POS_W-1:0]     pix_pos;
    logic [tra_pkg::CFG_DIM_W-1:0] width_reg;
    logic [tra_pkg::CFG_DIM_W-1:0] height_reg;
    logic [tra_pkg::WIN_W-1:0]     window_reg;

    avg_pixel_t                    expected_pixels [$];
    avg_pixel_t                    head;
    avg_pixel_t                    fresh_px;

    function automatic logic [tra_pkg::WEIGHT_W-1:0] gap_weight(
        input logic [tra_pkg::TIME_W-1:0] gap);
        if (window_reg == '0 || gap >= tra_pkg::TIME_W'(window_reg))
            return tra_pkg::WEIGHT_ONE;
        return tra_pkg::WEIGHT_W'((gap << tra_pkg::FRAC_W) / tra_pkg::TIME_W'(window_reg));
    endfunction

    // Mix one channel, round half to even, saturate at 255
    function automatic logic [tra_pkg::PIX_W-1:0] blend_lane(
        input logic [tra_pkg::PIX_W-1:0]    fresh,
        input logic [tra_pkg::PIX_W-1:0]    prior,
        input logic [tra_pkg::WEIGHT_W-1:0] alpha);
        logic [31:0] sum;
        logic [31:0] q;
        logic [15:0] rem;

        sum = 32'(alpha) * 32'(fresh)
            + (32'(tra_pkg::WEIGHT_ONE) - 32'(alpha)) * 32'(prior);
        q   = sum >> tra_pkg::FRAC_W;
        rem = sum[15:0];
        if (rem > 16'h8000 || (rem == 16'h8000 && q[0]))
            q = q + 1;
        return (q > 32'd255) ? 8'hFF : q[tra_pkg::PIX_W-1:0];
    endfunction

    function automatic logic [tra_pkg::RGB_W-1:0] stored_at(
        input logic [tra_pkg::POS_W-1:0] pos);
        return avg_mem.exists(32'(pos)) ? avg_mem[32'(pos)] : '0;
    endfunction

    function automatic avg_pixel_t advance_average(
        input logic [tra_pkg::S_TDATA_W-1:0] beat,
        input logic                          first);
        logic [tra_pkg::TIME_W-1:0] stamp;
        logic [tra_pkg::TIME_W-1:0] gap;
        logic [tra_pkg::PIX_W-1:0]  r;
        logic [tra_pkg::PIX_W-1:0]  g;
        logic [tra_pkg::PIX_W-1:0]  b;
        logic [tra_pkg::AREA_W-1:0] area;
        logic [tra_pkg::POS_W-1:0]  bound;
        logic [tra_pkg::RGB_W-1:0]  prior;
        logic [tra_pkg::RGB_W-1:0]  val;
        avg_pixel_t                 res;

        stamp = beat[tra_pkg::TIME_W-1:0];
        r     = beat[tra_pkg::TIME_W +: tra_pkg::PIX_W];
        g     = beat[tra_pkg::TIME_W+tra_pkg::PIX_W +: tra_pkg::PIX_W];
        b     = beat[tra_pkg::TIME_W+2*tra_pkg::PIX_W +: tra_pkg::PIX_W];
        area  = tra_pkg::AREA_W'(width_reg) * tra_pkg::AREA_W'(height_reg);
        bound = (area < tra_pkg::AREA_W'(tra_pkg::FRAME_PIXELS))
              ? tra_pkg::POS_W'(area) : tra_pkg::POS_W'(tra_pkg::FRAME_PIXELS);
        val   = '0;
        res.updated = 1'b0;

        // Decide skip, copy or blend once per frame
        if (first) begin
            gap     = stamp - last_take_us;
            pix_pos = '0;
            if (avg_valid && gap < tra_pkg::MIN_GAP_US) begin
                in_taken = 1'b0;
            end else begin
                in_taken     = 1'b1;
                copy_frame   = !avg_valid;
                weight_q16   = copy_frame ? tra_pkg::WEIGHT_ONE : gap_weight(gap);
                last_take_us = stamp;
                avg_valid    = (stamp != '0);
            end
        end

        // Past the frame area nothing is stored and the beat reads as zero
        if (pix_pos < bound) begin
            if (in_taken) begin
                if (copy_frame) begin
                    val = {r, g, b};
                end else begin
                    prior = stored_at(pix_pos);
                    val = {blend_lane(r, prior[23:16], weight_q16),
                           blend_lane(g, prior[15:8], weight_q16),
                           blend_lane(b, prior[7:0], weight_q16)};
                end
                avg_mem[32'(pix_pos)] = val;
                res.updated = 1'b1;
            end else if (avg_valid) begin
                val = stored_at(pix_pos);
            end
            pix_pos = pix_pos + 1'b1;
        end

        res.red   = val[23:16];
        res.green = val[15:8];
        res.blue  = val[7:0];
        return res;
    endfunction

    task automatic check_field(input string label, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            avg_mem.delete();
            expected_pixels.delete();
            avg_valid      = 1'b0;
            in_taken       = 1'b0;
            copy_frame     = 1'b0;
            last_take_us   = '0;
            weight_q16     = '0;
            pix_pos        = '0;
            width_reg      = tra_pkg::WIDTH_RST;
            height_reg     = tra_pkg::HEIGHT_RST;
            window_reg     = tra_pkg::WINDOW_RST;
            fail_count     = 0;
            pending_pixels = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tra_pkg::CFG_FRAME_WIDTH: begin
                        width_reg = cfg_data[tra_pkg::CFG_DIM_W-1:0];
                        avg_valid = 1'b0;
                        in_taken  = 1'b0;
                    end
                    tra_pkg::CFG_FRAME_HEIGHT: begin
                        height_reg = cfg_data[tra_pkg::CFG_DIM_W-1:0];
                        avg_valid  = 1'b0;
                        in_taken   = 1'b0;
                    end
                    tra_pkg::CFG_AVG_WINDOW: begin
                        window_reg = cfg_data;
                    end
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                fresh_px        = advance_average(s_tdata, s_tuser[0]);
                expected_pixels = {expected_pixels, fresh_px};
            end

            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat with nothing expected, got data %h updated %0d",
                             $time, m_tdata, m_tuser[0]);
                end else begin
                    head = expected_pixels.pop_front();
                    check_field("avg_red", head.red, m_tdata[0 +: tra_pkg::PIX_W]);
                    check_field("avg_green", head.green,
                                m_tdata[tra_pkg::PIX_W +: tra_pkg::PIX_W]);
                    check_field("avg_blue", head.blue,
                                m_tdata[2*tra_pkg::PIX_W +: tra_pkg::PIX_W]);
                    check_field("frame_updated", head.updated, m_tuser[0]);
                end
            end

            pending_pixels = expected_pixels.size();
        end
    end

endmodule

>>> dv/tb.sv
module tb;

    localparam int unsigned PIXEL_TARGET  = 980;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;

    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [tra_pkg::S_TDATA_W-1:0]  s_tdata   = '0;   // frame_time, red, green, blue
    logic [0:0]                     s_tuser   = '0;   // first_pixel

    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [tra_pkg::M_TDATA_W-1:0]  m_tdata;          // avg_red, avg_green, avg_blue
    logic [0:0]                     m_tuser;          // frame_updated

    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [tra_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [tra_pkg::WIN_W-1:0]      cfg_data  = '0;

    int unsigned                    fail_count;
    int unsigned                    pending_pixels;

    // Sender's view of the frame size and of when the block copies a frame
    logic [tra_pkg::CFG_DIM_W-1:0]  cur_width     = tra_pkg::WIDTH_RST;
    logic [tra_pkg::CFG_DIM_W-1:0]  cur_height    = tra_pkg::HEIGHT_RST;
    logic                           model_has_avg = 1'b0;
    logic [tra_pkg::TIME_W-1:0]     model_last_ts = '0;
    int unsigned                    pixels_sent   = 0;
    int unsigned                    sender_calm   = 0;
    int unsigned                    rx_stall      = 0;
    int unsigned                    rx_calm       = 0;
    int unsigned                    quiet_cycles  = 0;

    timed_running_average_frame_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    running_average_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending_pixels (pending_pixels)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int unsigned draw_idle();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [tra_pkg::PIX_W-1:0] draw_channel();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return '0;
        if (roll < 30)
            return '1;
        return tra_pkg::PIX_W'($urandom());
    endfunction

    function automatic int unsigned frame_bound();
        int unsigned area;
        area = int'(cur_width) * int'(cur_height);
        return (area < tra_pkg::FRAME_PIXELS) ? area : tra_pkg::FRAME_PIXELS;
    endfunction

    task automatic push_pixel(input logic [tra_pkg::TIME_W-1:0] stamp, input logic first,
                              input logic [tra_pkg::PIX_W-1:0] r,
                              input logic [tra_pkg::PIX_W-1:0] g,
                              input logic [tra_pkg::PIX_W-1:0] b);
        int unsigned idle;
        idle = 0;
        if (sender_calm > 0)
            sender_calm--;
        else if ($urandom_range(0, 99) < 3)
            sender_calm = $urandom_range(20, 80);
        else
            idle = draw_idle();
        if (idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r, stamp};
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pixels_sent++;
    endtask

    // Send one frame; a negative fill picks each channel at random
    task automatic send_frame(input logic [tra_pkg::TIME_W-1:0] stamp,
                              input int unsigned count, input int fill);
        logic [tra_pkg::TIME_W-1:0] gap;
        logic                       taken;
        int unsigned                n;

        gap   = stamp - model_last_ts;
        taken = !model_has_avg || gap >= tra_pkg::MIN_GAP_US;
        n     = (count == 0) ? 1 : count;
        // A copied frame that leaves an average must fill the whole area,
        // since later frames read every position back
        if (taken && !model_has_avg && stamp != '0 && n < frame_bound())
            n = frame_bound();
        if (taken) begin
            model_last_ts = stamp;
            model_has_avg = (stamp != '0);
        end
        for (int unsigned i = 0; i < n; i++) begin
            if (fill < 0)
                push_pixel((i == 0) ? stamp : {$urandom(), $urandom()}, i == 0,
                           draw_channel(), draw_channel(), draw_channel());
            else
                push_pixel((i == 0) ? stamp : {$urandom(), $urandom()}, i == 0,
                           tra_pkg::PIX_W'(fill), tra_pkg::PIX_W'(fill),
                           tra_pkg::PIX_W'(fill));
        end
    endtask

    // Drop the input and hold until every result beat has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_pixels != 0);
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [tra_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tra_pkg::WIN_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == tra_pkg::CFG_FRAME_WIDTH) begin
            cur_width     = value[tra_pkg::CFG_DIM_W-1:0];
            model_has_avg = 1'b0;
        end else if (idx == tra_pkg::CFG_FRAME_HEIGHT) begin
            cur_height    = value[tra_pkg::CFG_DIM_W-1:0];
            model_has_avg = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        logic ready_now;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            ready_now = 1'b1;
            if (rx_calm > 0) begin
                rx_calm--;
            end else if (rx_stall > 0) begin
                rx_stall--;
                ready_now = 1'b0;
            end else begin
                rx_stall = draw_idle();
                if ($urandom_range(0, 99) < 3)
                    rx_calm = $urandom_range(20, 100);
            end
            m_tready <= ready_now;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timed_running_average_frame_core test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [tra_pkg::TIME_W-1:0] stamp;
        logic [tra_pkg::WIN_W-1:0]  window_val;
        int unsigned                bound;
        int unsigned                count;
        int unsigned                roll;
        int unsigned                phase_frames;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Stray beats before any frame, then a short zero-stamped frame at the reset size
        push_pixel({$urandom(), $urandom()}, 1'b0, 8'h00, 8'hFF, 8'h00);
        push_pixel({$urandom(), $urandom()}, 1'b0, 8'hFF, 8'h00, 8'hFF);
        send_frame('0, 3, -1);

        // 4096 by 4096, capped area; a zero stamp keeps the frame short legally
        write_reg(tra_pkg::CFG_FRAME_WIDTH, 32'd4096);
        write_reg(tra_pkg::CFG_FRAME_HEIGHT, 32'd4096);
        send_frame('0, 2, -1);

        // Single pixel frames: copy, excess beat, skip, full-weight blend
        write_reg(tra_pkg::CFG_FRAME_WIDTH, 32'd1);
        write_reg(tra_pkg::CFG_FRAME_HEIGHT, 32'd1);
        write_reg(tra_pkg::CFG_AVG_WINDOW, 32'd1);
        send_frame(64'd5, 1, 255);
        push_pixel({$urandom(), $urandom()}, 1'b0, 8'hFF, 8'hFF, 8'hFF);
        send_frame(64'd6, 1, -1);
        send_frame(64'd5 + tra_pkg::MIN_GAP_US, 1, 0);

        // Half weight exposes round-half-to-even
        write_reg(tra_pkg::CFG_AVG_WINDOW, 32'd2000000);
        send_frame(model_last_ts + 64'd5000000, 1, 1);
        send_frame(model_last_ts + tra_pkg::MIN_GAP_US, 1, 2);
        send_frame(model_last_ts + tra_pkg::MIN_GAP_US, 1, 1);
        send_frame(model_last_ts + tra_pkg::MIN_GAP_US, 1, 5);

        // Widest window: tiny weight, gap just short, wrapped gap, all-ones stamp
        write_reg(tra_pkg::CFG_AVG_WINDOW, '1);
        send_frame(model_last_ts + tra_pkg::MIN_GAP_US, 1, 128);
        send_frame(model_last_ts + tra_pkg::MIN_GAP_US - 1, 1, -1);
        send_frame(model_last_ts - 1, 1, -1);
        send_frame('1, 1, -1);

        while (pixels_sent < PIXEL_TARGET) begin
            case ($urandom_range(0, 9)) inside
                [0:5]: begin
                    write_reg(tra_pkg::CFG_FRAME_WIDTH, $urandom_range(1, 8));
                    write_reg(tra_pkg::CFG_FRAME_HEIGHT, $urandom_range(1, 8));
                end
                [6:7]: begin
                    write_reg(tra_pkg::CFG_FRAME_WIDTH, $urandom_range(1, 48));
                    write_reg(tra_pkg::CFG_FRAME_HEIGHT, 32'd1);
                end
                8: begin
                    write_reg(tra_pkg::CFG_FRAME_HEIGHT, $urandom_range(1, 48));
                    write_reg(tra_pkg::CFG_FRAME_WIDTH, 32'd1);
                end
                default: ;
            endcase
            case ($urandom_range(0, 9)) inside
                0: write_reg(tra_pkg::CFG_AVG_WINDOW, 32'd1);
                1: write_reg(tra_pkg::CFG_AVG_WINDOW, '1);
                [2:6]: write_reg(tra_pkg::CFG_AVG_WINDOW, $urandom_range(1000000, 4000000));
                [7:8]: begin
                    window_val = $urandom();
                    write_reg(tra_pkg::CFG_AVG_WINDOW,
                              (window_val == '0) ? 32'd1 : window_val);
                end
                default: ;
            endcase

            phase_frames = $urandom_range(3, 10);
            repeat (phase_frames) begin
                case ($urandom_range(0, 19)) inside
                    0: stamp = '0;
                    [1:2]: stamp = {$urandom(), $urandom()};
                    3: stamp = model_last_ts + tra_pkg::MIN_GAP_US - 1;
                    4: stamp = model_last_ts + tra_pkg::MIN_GAP_US;
                    [5:7]: stamp = model_last_ts + 64'($urandom_range(0, 999999));
                    default: stamp = model_last_ts + tra_pkg::MIN_GAP_US
                                   + 64'($urandom_range(0, 8000000));
                endcase
                bound = frame_bound();
                roll  = $urandom_range(0, 19);
                if (roll < 14)
                    count = bound;
                else if (roll < 17)
                    count = bound + $urandom_range(1, 3);
                else
                    count = $urandom_range(1, bound);

                if ($urandom_range(0, 19) == 0)
                    wait_drained();
                send_frame(stamp, count, -1);
                if ($urandom_range(0, 11) == 0) begin
                    repeat ($urandom_range(1, 3))
                        push_pixel({$urandom(), $urandom()}, 1'b0,
                                   draw_channel(), draw_channel(), draw_channel());
                end
            end
        end

        wait_drained();
        repeat (64) @(posedge aclk);
        if (fail_count == 0)
            $display("timed_running_average_frame_core test passed");
        else
            $display("timed_running_average_frame_core test failed");
        $finish;
    end

endmodule
